// File: sv/hpt_pkg.sv
// hpt_pkg: shared types, constants and reset values for the point transform
// no dependencies; imported by every module of the block
`default_nettype none
package hpt_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int FIX_W      = 32;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 66;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = REG_IDX_W + 1;
    localparam int CFG_W      = 64;
    localparam int DIV_BITS   = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int NUM_COLS   = 4;
    localparam int COL_W      = 3;

    // register indexes of the matrix bank
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    typedef logic signed [FIX_W-1:0] t_fix;

    typedef struct packed {
        t_fix in_x;
        t_fix in_y;
        t_fix in_z;
    } t_point;

    typedef struct packed {
        t_fix out_x;
        t_fix out_y;
        t_fix out_z;
        logic w_was_zero;
        logic saturated;
    } t_result;

    // column sums as sign and magnitude, column 3 is w
    typedef struct packed {
        logic [NUM_COLS-1:0]              neg;
        logic [NUM_COLS-1:0][PROD_W-1:0]  mag;
        logic                             w_zero;
    } t_job;

    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(64'd1 << (FRAC_BITS + FIX_W));

    // identity matrix
    function automatic logic [CFG_W-1:0] reset_row(input logic [REG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        case (idx)
            REG_ROW0_COLS01: v = ONE_LO;
            REG_ROW1_COLS01: v = ONE_HI;
            REG_ROW2_COLS23: v = ONE_LO;
            REG_ROW3_COLS23: v = ONE_HI;
            default:         v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: sv/hpt_front.sv
// hpt_front: matrix registers, products and exact column sums
// depends on hpt_pkg
`default_nettype none
module hpt_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    input  wire hpt_pkg::t_point               i_item,
    input  wire logic                          i_cfg_valid,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hpt_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output hpt_pkg::t_job                      o_job
);
    import hpt_pkg::*;

    logic [CFG_W-1:0]         r_regs [NUM_REGS];
    logic signed [FIX_W-1:0]  w_coef [4][NUM_COLS];
    logic signed [FIX_W-1:0]  w_pt   [3];
    logic signed [PROD_W-1:0] r_prod [NUM_COLS][4];
    logic signed [SUM_W-1:0]  r_sum  [NUM_COLS];
    logic                     r_v1, r_v2, r_v3;
    t_job                     r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= reset_row(REG_IDX_W'(i));
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_regs[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
                w_coef[r][c] = (c % 2 == 1)
                             ? r_regs[REG_IDX_W'(r*2 + c/2)][CFG_W-1:FIX_W]
                             : r_regs[REG_IDX_W'(r*2 + c/2)][FIX_W-1:0];
            end
        end
        w_pt[0] = i_item.in_x;
        w_pt[1] = i_item.in_y;
        w_pt[2] = i_item.in_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_COLS; c++) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[c][r] <= PROD_W'(w_pt[r]) * PROD_W'(w_coef[r][c]);
            end
            // translation row times the implied 1.0
            r_prod[c][3] <= $signed({{(PROD_W-FIX_W-FRAC_BITS){w_coef[3][c][FIX_W-1]}},
                                     w_coef[3][c], {FRAC_BITS{1'b0}}});
        end
        for (int c = 0; c < NUM_COLS; c++) begin
            r_sum[c] <= SUM_W'(r_prod[c][0]) + SUM_W'(r_prod[c][1])
                      + SUM_W'(r_prod[c][2]) + SUM_W'(r_prod[c][3]);
        end
        for (int c = 0; c < NUM_COLS; c++) begin
            r_job.neg[c] <= r_sum[c][SUM_W-1];
            r_job.mag[c] <= r_sum[c][SUM_W-1] ? PROD_W'(-r_sum[c]) : r_sum[c][PROD_W-1:0];
        end
        r_job.w_zero <= (r_sum[NUM_COLS-1] == '0);
    end

    assign o_valid = r_v3;
    assign o_job   = r_job;
endmodule
`default_nettype wire

// File: sv/hpt_fifo.sv
// hpt_fifo: short queue of jobs between front and back
// depends on hpt_pkg
`default_nettype none
module hpt_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hpt_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic               o_full,
    output hpt_pkg::t_job      o_job
);
    import hpt_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule
`default_nettype wire

// File: sv/hpt_back.sv
// hpt_back: pipelined restoring divide of x, y, z by w, then clamp
// depends on hpt_pkg
`default_nettype none
module hpt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire hpt_pkg::t_job i_job,
    output logic               o_valid,
    output hpt_pkg::t_result   o_result
);
    import hpt_pkg::*;

    localparam int ST = DIV_BITS;

    logic                r_v    [ST+1];
    logic [PROD_W-1:0]   r_den  [ST+1];
    logic                r_wz   [ST+1];
    logic [PROD_W-1:0]   r_rem  [ST+1][COL_W];
    logic [DIV_BITS-1:0] r_lo   [ST+1][COL_W];
    logic [DIV_BITS-1:0] r_q    [ST+1][COL_W];
    logic                r_sgn  [ST+1][COL_W];
    logic                r_big  [ST+1][COL_W];

    logic [PROD_W:0]     w_trial [ST][COL_W];
    logic [PROD_W:0]     w_diff  [ST][COL_W];
    logic                w_ge    [ST][COL_W];

    logic [FIX_W-1:0]    w_res [COL_W];
    logic [COL_W-1:0]    w_sat;
    logic                r_out_v;
    t_result             r_out;

    always_comb begin
        for (int s = 0; s < ST; s++) begin
            for (int l = 0; l < COL_W; l++) begin
                w_trial[s][l] = {r_rem[s][l], r_lo[s][l][DIV_BITS-1]};
                w_ge[s][l]    = (w_trial[s][l] >= {1'b0, r_den[s]});
                w_diff[s][l]  = w_trial[s][l] - {1'b0, r_den[s]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ST; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 0; s < ST; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_out_v <= r_v[ST];
        end
    end

    always_ff @(posedge i_clk) begin
        // entry: quotient fits 32 bits unless num >= den * 2^frac
        r_den[0] <= i_job.mag[COL_W];
        r_wz[0]  <= i_job.w_zero;
        for (int l = 0; l < COL_W; l++) begin
            r_big[0][l] <= ({{FRAC_BITS{1'b0}}, i_job.mag[l]}
                            >= {i_job.mag[COL_W], {FRAC_BITS{1'b0}}});
            r_rem[0][l] <= i_job.mag[l] >> (DIV_BITS - FRAC_BITS);
            r_lo[0][l]  <= {i_job.mag[l][DIV_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_q[0][l]   <= '0;
            r_sgn[0][l] <= i_job.neg[l] ^ i_job.neg[COL_W];
        end
        // one quotient bit per stage
        for (int s = 0; s < ST; s++) begin
            r_den[s+1] <= r_den[s];
            r_wz[s+1]  <= r_wz[s];
            for (int l = 0; l < COL_W; l++) begin
                r_rem[s+1][l] <= w_ge[s][l] ? w_diff[s][l][PROD_W-1:0]
                                            : w_trial[s][l][PROD_W-1:0];
                r_lo[s+1][l]  <= {r_lo[s][l][DIV_BITS-2:0], 1'b0};
                r_q[s+1][l]   <= {r_q[s][l][DIV_BITS-2:0], w_ge[s][l]};
                r_sgn[s+1][l] <= r_sgn[s][l];
                r_big[s+1][l] <= r_big[s][l];
            end
        end
    end

    // an oversized quotient is never zero, whatever the divide left in r_q
    always_comb begin
        for (int l = 0; l < COL_W; l++) begin
            w_res[l] = '0;
            w_sat[l] = 1'b0;
            if (r_wz[ST]) begin
                w_res[l] = '0;
            end else if (r_sgn[ST][l] && (r_big[ST][l] || (r_q[ST][l] != '0))) begin
                if (r_big[ST][l] || (r_q[ST][l] > {1'b1, {(DIV_BITS-1){1'b0}}})) begin
                    w_res[l] = {1'b1, {(FIX_W-1){1'b0}}};
                    w_sat[l] = 1'b1;
                end else begin
                    w_res[l] = -r_q[ST][l];
                end
            end else begin
                if (r_big[ST][l] || r_q[ST][l][DIV_BITS-1]) begin
                    w_res[l] = {1'b0, {(FIX_W-1){1'b1}}};
                    w_sat[l] = 1'b1;
                end else begin
                    w_res[l] = r_q[ST][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.out_x      <= w_res[0];
        r_out.out_y      <= w_res[1];
        r_out.out_z      <= w_res[2];
        r_out.w_was_zero <= r_wz[ST];
        r_out.saturated  <= |w_sat;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;
endmodule
`default_nettype wire

// File: sv/homogeneous_point_transform_top.sv
// homogeneous_point_transform_top: 4x4 point transform with divide by w
// depends on hpt_pkg, hpt_front, hpt_fifo, hpt_back
//
// channel  | direction | handshake                 | payload
// point    | in        | start, busy               | i_item (t_point)
// matrix   | in        | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
// result   | out       | o_valid strobe            | o_result (t_result)
//
// one item per clock, sustained; the result strobe comes after the item has passed
// three front stages (products, sums, sign/magnitude), the queue, the divide
// entry register, 32 divide stages (one quotient bit a stage) and the clamp register
// synchronous active-low reset loads the identity matrix and empties the pipe
// the receiver cannot stall; the back end drains the queue every cycle, so
// busy only rises if the queue ever fills
`default_nettype none
module homogeneous_point_transform_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire hpt_pkg::t_point               i_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hpt_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_valid,
    output hpt_pkg::t_result                   o_result
);
    import hpt_pkg::*;

    logic w_take;
    logic w_front_v;
    t_job w_front_job;
    logic w_empty, w_full;
    t_job w_head;

    // item accepted on start while not busy
    assign busy        = w_full;
    assign w_take      = start && !busy;
    assign o_cfg_ready = 1'b1;

    hpt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (w_front_v),
        .o_job       (w_front_job)
    );

    // queue between classify and divide
    hpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_v),
        .i_job   (w_front_job),
        .i_pop   (!w_empty),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_job   (w_head)
    );

    hpt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_job    (w_head),
        .o_valid  (o_valid),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

// File: verif/tb.sv
// tb: self-checking testbench for homogeneous_point_transform_top
// depends on hpt_pkg and the block's rtl; predicts each result and checks it
// directed table first, then random matrices and points over several idle phases
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    // kinds of matrix loaded between phases
    typedef enum int {
        MAT_IDENTITY, MAT_ZERO, MAT_BIG_SCALE, MAT_NEG_W,
        MAT_RANDOM, MAT_AFFINE, MAT_EXTREME, MAT_SMALL_W
    } t_mat_kind;

    localparam int SETTLE_CYCLES = 60;   // longer than the whole pipe

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_point             i_item;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_valid;
    t_result            o_result;

    homogeneous_point_transform_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // own copy of the matrix bank, follows every accepted register write
    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    t_result          pending_results [$];
    int               mismatches;
    t_mat_kind        cur_kind;

    function automatic logic signed [67:0] coef_of(int r, int c);
        logic [CFG_W-1:0] reg_val;
        logic signed [31:0] half;
        reg_val = matrix_regs[r * 2 + c / 2];
        half = (c % 2) ? reg_val[63:32] : reg_val[31:0];
        return half;
    endfunction

    // x, y, z, 1 times the matrix, then exact scaled divide by w with clamp
    function automatic t_result transform_point(t_point p);
        logic signed [67:0] px, py, pz, col_sum [4];
        logic [127:0]       w_mag, num, quo;
        logic [31:0]        res [3];
        logic               neg, sat;
        t_result            r;
        px = p.in_x;
        py = p.in_y;
        pz = p.in_z;
        sat = 1'b0;
        for (int c = 0; c < 4; c++)
            col_sum[c] = px * coef_of(0, c) + py * coef_of(1, c) + pz * coef_of(2, c)
                         + (coef_of(3, c) <<< FRAC_BITS);
        if (col_sum[3] == 0) begin
            r = '0;
            r.w_was_zero = 1'b1;
            return r;
        end
        w_mag = col_sum[3][67] ? 128'(-col_sum[3]) : 128'(col_sum[3]);
        for (int c = 0; c < 3; c++) begin
            num = col_sum[c][67] ? 128'(-col_sum[c]) : 128'(col_sum[c]);
            quo = (num << FRAC_BITS) / w_mag;
            neg = (col_sum[c][67] != col_sum[3][67]) && quo != 0;
            if (neg) begin
                if (quo > 128'h8000_0000) begin
                    quo = 128'h8000_0000;
                    sat = 1'b1;
                end
                res[c] = -quo[31:0];
            end else begin
                if (quo > 128'h7FFF_FFFF) begin
                    quo = 128'h7FFF_FFFF;
                    sat = 1'b1;
                end
                res[c] = quo[31:0];
            end
        end
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        r.w_was_zero = 1'b0;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch at %0t on %s: got %h, want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    // monitor: takes in items and register writes, checks every result strobe
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < NUM_REGS)
                matrix_regs[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
            if (start && !busy)
                pending_results.push_back(transform_point(i_item));
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("tb: result at %0t with no item outstanding", $realtime);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.out_x !== want.out_x)
                        report_mismatch("out_x", o_result.out_x, want.out_x);
                    if (o_result.out_y !== want.out_y)
                        report_mismatch("out_y", o_result.out_y, want.out_y);
                    if (o_result.out_z !== want.out_z)
                        report_mismatch("out_z", o_result.out_z, want.out_z);
                    if (o_result.w_was_zero !== want.w_was_zero)
                        report_mismatch("w_was_zero", o_result.w_was_zero, want.w_was_zero);
                    if (o_result.saturated !== want.saturated)
                        report_mismatch("saturated", o_result.saturated, want.saturated);
                end
            end
        end
    end

    // pass a point in, with random idle cycles first at the given percentage
    task automatic send_point(t_point p, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= p;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and let every outstanding result come home
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // valid stays up across back-to-back writes; the caller drops it after the last
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic logic [31:0] rand_coef(t_mat_kind kind);
        case (kind)
            MAT_EXTREME: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            MAT_SMALL_W: return 32'($signed($urandom_range(4)) - 2) << FRAC_BITS;
            default:     return $urandom;
        endcase
    endfunction

    // load a whole matrix; writes all eight registers plus an out-of-range one
    task automatic load_matrix(t_mat_kind kind);
        logic [CFG_W-1:0] v [NUM_REGS];
        drain();
        cur_kind = kind;
        for (int i = 0; i < NUM_REGS; i++) v[i] = '0;
        case (kind)
            MAT_IDENTITY: begin
                v[REG_ROW0_COLS01] = 64'h0000_0000_0001_0000;
                v[REG_ROW1_COLS01] = 64'h0001_0000_0000_0000;
                v[REG_ROW2_COLS23] = 64'h0000_0000_0001_0000;
                v[REG_ROW3_COLS23] = 64'h0001_0000_0000_0000;
            end
            MAT_ZERO: ;     // w always zero
            MAT_BIG_SCALE: begin
                v[REG_ROW0_COLS01] = 64'h8000_0000_7FFF_FFFF;
                v[REG_ROW1_COLS01] = 64'h7FFF_FFFF_0000_0000;
                v[REG_ROW2_COLS23] = 64'h0000_0000_7FFF_FFFF;
                v[REG_ROW3_COLS23] = 64'h0000_0001_0000_0000;
            end
            MAT_NEG_W: begin
                // tiny quotients of opposite sign truncate to zero
                v[REG_ROW0_COLS01] = 64'h0000_0000_0001_0000;
                v[REG_ROW1_COLS01] = 64'h0001_0000_0000_0000;
                v[REG_ROW2_COLS23] = 64'h0000_0000_0001_0000;
                v[REG_ROW3_COLS23] = 64'h8000_0000_0000_0000;
            end
            MAT_AFFINE: begin
                for (int i = 0; i < NUM_REGS; i++)
                    v[i] = {(i % 2) ? 32'h0 : rand_coef(kind), rand_coef(kind)};
                v[REG_ROW3_COLS23][63:32] = $urandom_range(1) ? 32'h0001_0000 : $urandom;
            end
            default: begin
                for (int i = 0; i < NUM_REGS; i++)
                    v[i] = {rand_coef(kind), rand_coef(kind)};
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), v[i]);
        write_reg(CFG_IDX_W'($urandom_range(15, NUM_REGS)), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($signed($urandom_range(4)) - 2) << FRAC_BITS;
            3:       return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    typedef struct {
        t_mat_kind kind;
        t_point    pt;
        bit        has_want;
        t_result   want;
    } t_row;

    t_row directed_rows [$];

    function automatic void add_row(t_mat_kind kind, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, bit has_want, t_result want);
        t_row r;
        r.kind = kind;
        r.pt = '{in_x: x, in_y: y, in_z: z};
        r.has_want = has_want;
        r.want = want;
        directed_rows.push_back(r);
    endfunction

    initial begin
        t_result typed;
        t_result got_pred;
        t_point  p;
        int      idle_modes [3];
        int      idle_pct;
        idle_modes  = '{0, 64, 15};
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        mismatches  = 0;
        cur_kind    = MAT_IDENTITY;
        // identity matrix after reset
        for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
        matrix_regs[REG_ROW0_COLS01] = 64'h0000_0000_0001_0000;
        matrix_regs[REG_ROW1_COLS01] = 64'h0001_0000_0000_0000;
        matrix_regs[REG_ROW2_COLS23] = 64'h0000_0000_0001_0000;
        matrix_regs[REG_ROW3_COLS23] = 64'h0001_0000_0000_0000;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity passes the point through unchanged
        typed = '{out_x: 32'h0, out_y: 32'h0, out_z: 32'h0, w_was_zero: 1'b0, saturated: 1'b0};
        add_row(MAT_IDENTITY, 0, 0, 0, 1, typed);
        typed = '{out_x: 32'h7FFF_FFFF, out_y: 32'h8000_0000, out_z: 32'h0001_0000,
                  w_was_zero: 1'b0, saturated: 1'b0};
        add_row(MAT_IDENTITY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1, typed);
        typed = '{out_x: 32'h8000_0000, out_y: 32'hFFFF_FFFF, out_z: 32'h7FFF_FFFF,
                  w_was_zero: 1'b0, saturated: 1'b0};
        add_row(MAT_IDENTITY, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, typed);
        add_row(MAT_IDENTITY, 1, 32'hFFFF_0000, 32'h1234_5678, 0, typed);
        // zero matrix: w is zero whatever the point
        typed = '{out_x: 32'h0, out_y: 32'h0, out_z: 32'h0, w_was_zero: 1'b1, saturated: 1'b0};
        add_row(MAT_ZERO, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, typed);
        add_row(MAT_ZERO, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, typed);
        add_row(MAT_ZERO, 0, 0, 0, 1, typed);
        // huge scale with tiny w: quotients clamp both ways
        add_row(MAT_BIG_SCALE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, typed);
        add_row(MAT_BIG_SCALE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, typed);
        add_row(MAT_BIG_SCALE, 0, 0, 0, 0, typed);
        add_row(MAT_BIG_SCALE, 1, 32'hFFFF_FFFF, 2, 0, typed);
        // large negative w: opposite-sign quotients that truncate to zero
        add_row(MAT_NEG_W, 1, 32'hFFFF_FFFF, 0, 0, typed);
        add_row(MAT_NEG_W, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, typed);
        add_row(MAT_NEG_W, 32'h0000_8000, 32'hFFFF_8000, 32'h4000_0000, 0, typed);
        add_row(MAT_EXTREME, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, typed);
        add_row(MAT_SMALL_W, 32'h0001_0000, 32'hFFFF_0000, 0, 0, typed);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind != cur_kind || i == 0)
                load_matrix(directed_rows[i].kind);
            if (directed_rows[i].has_want) begin
                // the table value must agree with the predictor
                got_pred = transform_point(directed_rows[i].pt);
                if (got_pred !== directed_rows[i].want) begin
                    $display("tb: table row %0d disagrees with prediction", i);
                    mismatches++;
                end
            end
            send_point(directed_rows[i].pt, 0);
        end

        // random part: new matrix each phase, idle modes rotate
        for (int ph = 0; ph < 17; ph++) begin
            load_matrix(t_mat_kind'(ph < 4 ? MAT_RANDOM + ph : $urandom_range(MAT_SMALL_W)));
            idle_pct = idle_modes[ph % 3];
            for (int n = 0; n < 100; n++) begin
                if (cur_kind == MAT_SMALL_W)
                    p = '{in_x: 32'($signed($urandom_range(4)) - 2) << FRAC_BITS,
                          in_y: 32'($signed($urandom_range(4)) - 2) << FRAC_BITS,
                          in_z: 32'($signed($urandom_range(4)) - 2) << FRAC_BITS};
                else
                    p = '{in_x: rand_field(), in_y: rand_field(), in_z: rand_field()};
                // hold off once until the pipe is empty
                if (ph == 2 && n == 50) drain();
                send_point(p, idle_pct);
            end
        end

        drain();
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
